@@ rtl/sts_pkg.sv @@
// Shared types and constants of the section timing statistics block.
// Depends on nothing; every other file in rtl/ imports it.
package sts_pkg;

	localparam int CODE_W    = 4;
	localparam int SAMPLE_W  = 31;
	localparam int MIN_W     = 30;
	localparam int MAX_W     = 31;
	localparam int TOTAL_W   = 48;
	localparam int MEAN_W    = 40;
	localparam int PCT_W     = 15;
	localparam int FRAMES_W  = 32;
	localparam int LIMIT_W   = 16;
	localparam int DIVIDEND_W = 64;

	localparam logic [MIN_W-1:0]    MIN_INIT      = MIN_W'(999999999);
	localparam logic [FRAMES_W-1:0] TIMED_RESET   = FRAMES_W'(601);
	localparam logic [LIMIT_W-1:0]  DEFAULT_LIMIT = LIMIT_W'(600);
	localparam logic [PCT_W-1:0]    PCT_FULL      = PCT_W'(25600);

	localparam logic CFG_ENABLE = 1'b0;
	localparam logic CFG_LIMIT  = 1'b1;

	typedef struct packed {
		logic [MIN_W-1:0]   min_v;
		logic [MAX_W-1:0]   max_v;
		logic [TOTAL_W-1:0] total_v;
		logic [MEAN_W-1:0]  mean_v;
		logic [PCT_W-1:0]   pct_v;
	} sts_entry_t;

endpackage

@@ rtl/sts_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle, shared by both divisions.
// Depends on sts_pkg for the dividend width.
module sts_div #(
	parameter int DW = 44
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [sts_pkg::DIVIDEND_W-1:0]    dividend,
	input  logic [DW-1:0]                     divisor,
	output logic                              done,
	output logic [sts_pkg::DIVIDEND_W-1:0]    quotient
);
	import sts_pkg::*;

	localparam int CW = $clog2(DIVIDEND_W);

	logic [DW-1:0]         rem_q;
	logic [DIVIDEND_W-1:0] acc_q;
	logic [DW-1:0]         dsr_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DW:0]           shifted;
	logic [DW:0]           diff;
	logic                  ge;

	assign shifted = {rem_q, acc_q[DIVIDEND_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign ge      = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIVIDEND_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			acc_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
			acc_q <= {acc_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q)) else $error("divider done without a run");
	a_remainder_below: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start |-> rem_q < dsr_q) else $error("divider remainder out of range");

endmodule

@@ rtl/sts_table.sv @@
// Per-section statistics memory with one valid bit per entry for instant clearing.
// Depends on sts_pkg for the entry type.
module sts_table #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clr,
	input  logic                    rd_en,
	input  logic [AW-1:0]           rd_addr,
	output sts_pkg::sts_entry_t     rd_data,
	input  logic                    wr_en,
	input  logic [AW-1:0]           wr_addr,
	input  sts_pkg::sts_entry_t     wr_data
);
	import sts_pkg::*;

	sts_entry_t       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	sts_entry_t       rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// An entry never written since the last clear reads as all zero.
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

@@ rtl/section_timing_statistics.sv @@
// Section timing statistics monitor: top level with sequencer, counters and output register.
// Depends on sts_pkg, sts_table and sts_div.
//
// Each input word names a code section and the nanoseconds since the previous
// mark; the block answers with one output word holding that section's minimum,
// maximum, saturating total, mean per timed frame and share of the sum of all
// means. Code 0 marks a frame boundary. When the timed frame count exceeds
// the configured limit the mark clears all statistics instead (cleared is 1) and
// its sample is dropped; right after reset the first enabled mark clears. With
// enable low every word is taken and dropped without an answer. Words are
// handled one at a time and in_stall stays high while one is in work. A
// recording mark passes through a table read, the mean division and, when the
// percent is divided too, the percent division, then the output load; both
// divisions run in the single shared one-bit-per-cycle divider. Clearing
// marks, out-of-range codes and marks before the first timed frame skip the
// divisions. A finished word waits in the output register, so a stalled
// output only delays the next word's answer.
module section_timing_statistics #(
	parameter int NUM_SECTIONS   = 16,
	parameter int MEAN_FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [sts_pkg::LIMIT_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sts_pkg::CODE_W-1:0]    section_code,
	input  logic [sts_pkg::SAMPLE_W-1:0]  elapsed_ns,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sts_pkg::CODE_W-1:0]    out_section,
	output logic                          cleared,
	output logic [sts_pkg::MIN_W-1:0]     min_ns,
	output logic [sts_pkg::MAX_W-1:0]     max_ns,
	output logic [sts_pkg::TOTAL_W-1:0]   total_ns,
	output logic [sts_pkg::MEAN_W-1:0]    mean_ns_q8,
	output logic [sts_pkg::PCT_W-1:0]     percent_q8,
	output logic                          percent_valid,
	output logic [sts_pkg::FRAMES_W-1:0]  frame_count_total
);
	import sts_pkg::*;

	localparam int AW  = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
	// The sum of all means needs room for every section at full scale.
	localparam int MSW = MEAN_W + AW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_DIVM = 3'd2;
	localparam logic [2:0] S_DIVP = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]          state_q;
	logic                enable_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [FRAMES_W-1:0] timed_q;
	logic [FRAMES_W-1:0] all_q;
	logic [MSW-1:0]      msum_q;
	logic [CODE_W-1:0]   code_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                rec_q;
	logic                clr_q;
	logic                pvalid_q;
	sts_entry_t          ent_q;

	logic                accept;
	logic                code_zero;
	logic                in_range;
	logic                clr_now;
	logic [FRAMES_W-1:0] timed_next;

	sts_entry_t          rd_ent;
	sts_entry_t          upd_ent;
	logic [TOTAL_W:0]    tot_sum;
	logic [MIN_W-1:0]    min_base;

	logic                div_start;
	logic [DIVIDEND_W-1:0] div_dividend;
	logic [MSW-1:0]      div_divisor;
	logic                div_done;
	logic [DIVIDEND_W-1:0] div_q;
	logic [MEAN_W-1:0]   mean_sat;
	logic [MSW-1:0]      msum_new;
	logic [DIVIDEND_W-1:0] pct_num;
	logic                out_free;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign code_zero = (section_code == '0);
	assign in_range  = 32'(section_code) < NUM_SECTIONS;
	assign clr_now   = (limit_q != '0) && (timed_q > FRAMES_W'(limit_q));
	assign timed_next = timed_q + FRAMES_W'(code_zero);
	assign out_free  = !out_valid || !out_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			limit_q  <= DEFAULT_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE: enable_q <= cfg_data[0];
				CFG_LIMIT:  limit_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	sts_table #(
		.DEPTH(NUM_SECTIONS),
		.AW   (AW)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (accept && enable_q && clr_now),
		.rd_en  (accept),
		.rd_addr(AW'(section_code)),
		.rd_data(rd_ent),
		.wr_en  ((state_q == S_OUT) && out_free && rec_q),
		.wr_addr(AW'(code_q)),
		.wr_data(ent_q)
	);

	// Update of minimum, maximum and saturating total from the stored entry.
	always_comb begin
		upd_ent  = rd_ent;
		tot_sum  = {1'b0, rd_ent.total_v} + (TOTAL_W+1)'(sample_q);
		upd_ent.total_v = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
		min_base = (rd_ent.min_v == '0) ? MIN_INIT : rd_ent.min_v;
		if (sample_q == '0) begin
			upd_ent.min_v = MIN_W'(1);
		end else if (SAMPLE_W'(min_base) > sample_q) begin
			upd_ent.min_v = sample_q[MIN_W-1:0];
		end else begin
			upd_ent.min_v = min_base;
		end
		upd_ent.max_v = (rd_ent.max_v < sample_q) ? sample_q : rd_ent.max_v;
	end

	assign mean_sat = (div_q[DIVIDEND_W-1:MEAN_W] != '0) ? '1 : div_q[MEAN_W-1:0];
	assign msum_new = msum_q - MSW'(ent_q.mean_v) + MSW'(mean_sat);
	// Multiply by 25600 as three shifted adds.
	assign pct_num  = (DIVIDEND_W'(mean_sat) << 14) + (DIVIDEND_W'(mean_sat) << 13)
		+ (DIVIDEND_W'(mean_sat) << 10);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIVIDEND_W'(upd_ent.total_v) << MEAN_FRAC_BITS;
		div_divisor  = MSW'(timed_q);
		if (state_q == S_RD) begin
			div_start = (timed_q != '0);
		end else if (state_q == S_DIVM) begin
			div_dividend = pct_num;
			div_divisor  = msum_new;
			div_start    = div_done && (timed_q > FRAMES_W'(1)) && (msum_new != '0);
		end
	end

	sts_div #(
		.DW(MSW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_q)
	);

	// Sequencer and frame counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			timed_q   <= TIMED_RESET;
			all_q     <= '0;
			msum_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			// In S_OUT the output register is refilled below instead.
			if (out_valid && !out_stall && (state_q != S_OUT)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && enable_q) begin
						all_q <= all_q + FRAMES_W'(code_zero);
						if (clr_now) begin
							timed_q <= '0;
							msum_q  <= '0;
							state_q <= S_OUT;
						end else begin
							timed_q <= timed_next;
							state_q <= in_range ? S_RD : S_OUT;
						end
					end
				end
				S_RD: begin
					state_q <= (timed_q != '0) ? S_DIVM : S_OUT;
				end
				S_DIVM: begin
					if (div_done) begin
						msum_q  <= msum_new;
						state_q <= div_start ? S_DIVP : S_OUT;
					end
				end
				S_DIVP: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working payload of the word in flight and the output register.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					code_q   <= section_code;
					sample_q <= elapsed_ns;
					clr_q    <= clr_now;
					rec_q    <= !clr_now && in_range;
					pvalid_q <= 1'b0;
				end
			end
			S_RD: begin
				ent_q <= upd_ent;
			end
			S_DIVM: begin
				if (div_done) begin
					ent_q.mean_v <= mean_sat;
					if (timed_q > FRAMES_W'(1) && msum_new == '0) begin
						ent_q.pct_v <= '0;
					end
					pvalid_q <= div_start;
				end
			end
			S_DIVP: begin
				if (div_done) begin
					ent_q.pct_v <= div_q[PCT_W-1:0];
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_section       <= code_q;
					cleared           <= clr_q;
					min_ns            <= rec_q ? ent_q.min_v : '0;
					max_ns            <= rec_q ? ent_q.max_v : '0;
					total_ns          <= rec_q ? ent_q.total_v : '0;
					mean_ns_q8        <= rec_q ? ent_q.mean_v : '0;
					percent_q8        <= rec_q ? ent_q.pct_v : '0;
					percent_valid     <= rec_q && pvalid_q;
					frame_count_total <= all_q;
				end
			end
			default: ;
		endcase
	end

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIVM || state_q == S_DIVP))
		else $error("divider finished outside a division state");
	a_pct_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && percent_valid |-> percent_q8 <= PCT_FULL)
		else $error("percent above full scale");
	a_clear_zeros: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cleared |-> total_ns == '0 && percent_valid == 1'b0)
		else $error("clearing word carries statistics");
	a_clear_resets_timed: assert property (@(posedge clk) disable iff (!arst_n)
		accept && enable_q && clr_now |=> timed_q == '0 && msum_q == '0)
		else $error("clearing mark left frame state");

endmodule
